// ===== rtl/core/ilp_pkg.sv =====
`timescale 1ns / 1ps

package ilp_pkg;

  localparam int unsigned CharW   = 21;
  localparam int unsigned ValW    = 64;
  // The magnitude times sixteen plus a digit fits in four extra bits.
  localparam int unsigned MagExtW = ValW + 4;

  localparam logic [CharW-1:0] ChUnderscore = 21'h00005F;
  localparam logic [CharW-1:0] ChPlus       = 21'h00002B;
  localparam logic [CharW-1:0] ChMinus      = 21'h00002D;
  localparam logic [CharW-1:0] ChZero       = 21'h000030;
  localparam logic [CharW-1:0] ChNine       = 21'h000039;
  localparam logic [CharW-1:0] ChLowA       = 21'h000061;
  localparam logic [CharW-1:0] ChLowF       = 21'h000066;
  localparam logic [CharW-1:0] ChUpA        = 21'h000041;
  localparam logic [CharW-1:0] ChUpF        = 21'h000046;
  localparam logic [CharW-1:0] ChLowX       = 21'h000078;
  localparam logic [CharW-1:0] ChUpX        = 21'h000058;
  localparam logic [CharW-1:0] ChLowB       = 21'h000062;
  localparam logic [CharW-1:0] ChUpB        = 21'h000042;
  localparam logic [CharW-1:0] ChLowO       = 21'h00006F;
  localparam logic [CharW-1:0] ChUpO        = 21'h00004F;

  localparam logic [ValW-1:0] MagPosMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValW-1:0] MagNegMax = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    PhStart  = 4'b0001,
    PhSigned = 4'b0010,
    PhZero   = 4'b0100,
    PhBody   = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    RxDec = 2'd0,
    RxHex = 2'd1,
    RxBin = 2'd2,
    RxOct = 2'd3
  } radix_e;

  typedef struct packed {
    logic [ValW-1:0] magnitude;
    phase_e          phase;
    logic            is_negative;
    radix_e          radix;
    logic            prefix_pending;
    logic            saw_digit;
    logic            after_separator;
    logic            has_failed;
  } ilp_state_t;

  localparam ilp_state_t StateReset = '{
    magnitude:       '0,
    phase:           PhStart,
    is_negative:     1'b0,
    radix:           RxDec,
    prefix_pending:  1'b0,
    saw_digit:       1'b0,
    after_separator: 1'b0,
    has_failed:      1'b0
  };

endpackage

// ===== rtl/core/ilp_if.sv =====
`timescale 1ns / 1ps

interface ilp_char_if;
  logic                       valid;
  logic                       ready;
  logic [ilp_pkg::CharW-1:0]  char_code;
  logic                       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface ilp_result_if;
  logic                            valid;
  logic                            ready;
  logic signed [ilp_pkg::ValW-1:0] parsed_value;
  logic                            parse_ok;

  modport source (output valid, output parsed_value, output parse_ok, input ready);
  modport sink (input valid, input parsed_value, input parse_ok, output ready);
endinterface

// ===== rtl/core/ilp_step.sv =====
`timescale 1ns / 1ps

module ilp_step (
  input  ilp_pkg::ilp_state_t             state_i,
  input  logic [ilp_pkg::CharW-1:0]       char_code_i,
  input  logic                            last_char_i,
  output ilp_pkg::ilp_state_t             state_o,
  output logic signed [ilp_pkg::ValW-1:0] parsed_value_o,
  output logic                            parse_ok_o
);
  import ilp_pkg::*;

  radix_e             body_radix;
  logic               body_pp;
  logic               is_us;
  logic               is_dec;
  logic               is_lhex;
  logic               is_uhex;
  logic               dvalid;
  logic [3:0]         dval;
  logic               in_base;
  logic [MagExtW-1:0] shifted;
  logic [MagExtW-1:0] sum;
  logic [MagExtW-1:0] limit;
  logic               ovf;
  logic               us_fail;
  logic               body_fail;
  logic               use_body;
  logic               first;
  logic               ok;
  ilp_state_t         nxt;

  // The body step is shared by the first digit, the digit after a leading
  // zero and the digits of the body; only the radix and prefix flag differ.
  assign body_radix = (state_i.phase == PhBody) ? state_i.radix :
                      (state_i.phase == PhZero) ? RxOct : RxDec;
  assign body_pp    = (state_i.phase == PhZero) | state_i.prefix_pending;

  assign is_us   = (char_code_i == ChUnderscore);
  assign is_dec  = (char_code_i >= ChZero) && (char_code_i <= ChNine);
  assign is_lhex = (char_code_i >= ChLowA) && (char_code_i <= ChLowF);
  assign is_uhex = (char_code_i >= ChUpA) && (char_code_i <= ChUpF);
  assign dvalid  = is_dec | is_lhex | is_uhex;
  assign dval    = is_dec ? char_code_i[3:0] : 4'(char_code_i[3:0] + 4'd9);

  always_comb begin
    case (body_radix)
      RxHex:   begin
        in_base = 1'b1;
        shifted = {state_i.magnitude, 4'b0000};
      end
      RxBin:   begin
        in_base = (dval < 4'd2);
        shifted = {3'b000, state_i.magnitude, 1'b0};
      end
      RxOct:   begin
        in_base = (dval < 4'd8);
        shifted = {1'b0, state_i.magnitude, 3'b000};
      end
      default: begin
        in_base = (dval < 4'd10);
        shifted = {1'b0, state_i.magnitude, 3'b000} + {3'b000, state_i.magnitude, 1'b0};
      end
    endcase
  end

  // Comparing magnitude * base + digit against the limit is the same test
  // as comparing the magnitude against (limit - digit) / base.
  assign sum   = shifted + {{(MagExtW-4){1'b0}}, dval};
  assign limit = {4'b0000, (state_i.is_negative ? MagNegMax : MagPosMax)};
  assign ovf   = (sum > limit);

  assign us_fail   = state_i.after_separator | (~state_i.saw_digit & ~body_pp) | last_char_i;
  assign body_fail = is_us ? us_fail : (~dvalid | ~in_base | ovf);

  always_comb begin
    nxt      = state_i;
    use_body = 1'b0;
    first    = 1'b0;
    if (!state_i.has_failed) begin
      case (state_i.phase)
        PhStart: begin
          if (char_code_i == ChPlus || char_code_i == ChMinus) begin
            nxt.is_negative = (char_code_i == ChMinus);
            if (last_char_i) begin
              nxt.has_failed = 1'b1;
            end else begin
              nxt.phase = PhSigned;
            end
          end else begin
            first = 1'b1;
          end
        end
        PhSigned: begin
          first = 1'b1;
        end
        PhZero: begin
          nxt.phase          = PhBody;
          nxt.prefix_pending = 1'b1;
          if (char_code_i == ChLowX || char_code_i == ChUpX) begin
            nxt.radix = RxHex;
          end else if (char_code_i == ChLowB || char_code_i == ChUpB) begin
            nxt.radix = RxBin;
          end else if (char_code_i == ChLowO || char_code_i == ChUpO) begin
            nxt.radix = RxOct;
          end else begin
            nxt.radix = RxOct;
            use_body  = 1'b1;
          end
        end
        PhBody: begin
          use_body = 1'b1;
        end
        default: begin
          nxt.has_failed = 1'b1;
        end
      endcase

      if (first) begin
        if (char_code_i == ChZero && !last_char_i) begin
          nxt.phase = PhZero;
        end else begin
          nxt.phase = PhBody;
          nxt.radix = RxDec;
          use_body  = 1'b1;
        end
      end

      if (use_body) begin
        if (body_fail) begin
          nxt.has_failed = 1'b1;
        end else if (is_us) begin
          nxt.after_separator = 1'b1;
        end else begin
          nxt.magnitude       = sum[ValW-1:0];
          nxt.saw_digit       = 1'b1;
          nxt.after_separator = 1'b0;
          nxt.prefix_pending  = 1'b0;
        end
      end
    end
  end

  assign ok         = ~nxt.has_failed & nxt.saw_digit & ~nxt.after_separator;
  assign parse_ok_o = ok;

  always_comb begin
    if (!ok) begin
      parsed_value_o = '0;
    end else if (nxt.is_negative) begin
      parsed_value_o = signed'(ValW'(0) - nxt.magnitude);
    end else begin
      parsed_value_o = signed'(nxt.magnitude);
    end
  end

  // A literal ends with its last character; the next one starts afresh.
  assign state_o = last_char_i ? StateReset : nxt;

endmodule

// ===== rtl/core/integer_literal_parser.sv =====
`timescale 1ns / 1ps

// Integer literal parser.
// The in_i channel carries one character code point per transfer, with
// last_char set on the final character of a literal. Literals may carry a
// sign, a 0x, 0b or 0o prefix (or a bare leading zero for octal) and single
// underscores between digits or after a prefix. For every literal exactly one
// result leaves on out_o, with the signed 64-bit value and parse_ok; the value
// is zero when the literal is malformed or out of range.
// A character is taken into an input register, and from there the parse
// state and, for a last character, the result register are updated. One
// character is accepted per cycle while in_i does not stall; the limit is
// the combinational state update through the multiply-by-radix adder and
// range compare.
// While a result waits on out_o, characters that do not end a literal keep
// flowing; a second last character waits in the input register and in_i
// stalls until the result is taken.
// Reset empties both registers and returns the parse state to the start of
// a literal.
module integer_literal_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  ilp_char_if.sink     in_i,
  ilp_result_if.source out_o
);
  import ilp_pkg::*;

  logic                   in_valid_q;
  logic [CharW-1:0]       in_char_q;
  logic                   in_last_q;
  ilp_state_t             state_q;
  ilp_state_t             state_d;
  logic                   out_valid_q;
  logic signed [ValW-1:0] out_value_q;
  logic                   out_ok_q;
  logic signed [ValW-1:0] step_value;
  logic                   step_ok;
  logic                   out_free;
  logic                   consume;

  assign out_free   = ~out_valid_q | out_o.ready;
  assign consume    = in_valid_q & (~in_last_q | out_free);
  assign in_i.ready = ~in_valid_q | consume;

  ilp_step u_step (
    .state_i        (state_q),
    .char_code_i    (in_char_q),
    .last_char_i    (in_last_q),
    .state_o        (state_d),
    .parsed_value_o (step_value),
    .parse_ok_o     (step_ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_char_q <= in_i.char_code;
      in_last_q <= in_i.last_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (consume) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && in_last_q) begin
      out_value_q <= step_value;
      out_ok_q    <= step_ok;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.parsed_value = out_value_q;
  assign out_o.parse_ok     = out_ok_q;

endmodule

// ===== rtl/core/ilp_checker.sv =====
`timescale 1ns / 1ps

module ilp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            in_last_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic signed [ilp_pkg::ValW-1:0] out_value_i,
  input logic                            out_ok_i
);
  import ilp_pkg::*;

  // Literals whose last character has transferred in but whose result has
  // not yet transferred out. The block holds at most two of them.
  logic [1:0] pend_q;
  logic       last_in;
  logic       res_out;

  assign last_in = in_valid_i & in_ready_i & in_last_i;
  assign res_out = out_valid_i & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else if (last_in && !res_out) begin
      pend_q <= pend_q + 2'd1;
    end else if (!last_in && res_out) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(out_ok_i))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ok_i |-> out_value_i == '0)
    else $error("rejected literal carries a nonzero value");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without a finished literal");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many literals in flight");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_char),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.parsed_value),
  .out_ok_i    (out_o.parse_ok)
);
